[design/tdpid_pkg.sv]
// ============================================================================
// tdpid_pkg: shared types, constants and arithmetic for the 2-DOF PID block
// Holds the word formats, register indexes, the microcode table that drives
// the shared arithmetic unit, and the saturating add and multiply helpers.
// ============================================================================
package tdpid_pkg;

    // Number format: signed fixed point, DATA_W bits with FRAC_BITS fraction bits.
    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int LIMIT_W   = DATA_W - 1;

    typedef logic signed [DATA_W-1:0] data_t;

    localparam data_t DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam data_t DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam data_t DATA_ONE = data_t'(1) <<< FRAC_BITS;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_PROP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_DERIV = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_COEF   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_POLE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_COEF   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TRACK_GAIN   = 3'd7;

    // Payload words.
    typedef struct packed {
        logic signed [DATA_W-1:0] measured;
        logic signed [DATA_W-1:0] setpoint;
    } in_word_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] drive;
        logic                     clamped;
    } out_word_t;

    // Operations of the shared unit.
    localparam logic [1:0] OP_MUL   = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_SUB   = 2'd2;
    localparam logic [1:0] OP_CLAMP = 2'd3;

    // Operand sources.
    localparam logic [4:0] SRC_KP   = 5'd0;
    localparam logic [4:0] SRC_B    = 5'd1;
    localparam logic [4:0] SRC_C    = 5'd2;
    localparam logic [4:0] SRC_KI   = 5'd3;
    localparam logic [4:0] SRC_CD1  = 5'd4;
    localparam logic [4:0] SRC_CD2  = 5'd5;
    localparam logic [4:0] SRC_TG   = 5'd6;
    localparam logic [4:0] SRC_ACC  = 5'd7;
    localparam logic [4:0] SRC_DN   = 5'd8;
    localparam logic [4:0] SRC_DB   = 5'd9;
    localparam logic [4:0] SRC_TN   = 5'd10;
    localparam logic [4:0] SRC_TB   = 5'd11;
    localparam logic [4:0] SRC_SL   = 5'd12;
    localparam logic [4:0] SRC_SO   = 5'd13;
    localparam logic [4:0] SRC_ML   = 5'd14;
    localparam logic [4:0] SRC_MO   = 5'd15;
    localparam logic [4:0] SRC_W    = 5'd16;
    localparam logic [4:0] SRC_Y    = 5'd17;
    localparam logic [4:0] SRC_T1   = 5'd18;
    localparam logic [4:0] SRC_T2   = 5'd19;
    localparam logic [4:0] SRC_EDM1 = 5'd20;
    localparam logic [4:0] SRC_YP   = 5'd21;
    localparam logic [4:0] SRC_UOUT = 5'd22;

    // Result destinations.
    localparam logic [2:0] DST_T1   = 3'd0;
    localparam logic [2:0] DST_T2   = 3'd1;
    localparam logic [2:0] DST_EDM1 = 3'd2;
    localparam logic [2:0] DST_ACC  = 3'd3;
    localparam logic [2:0] DST_DN   = 3'd4;
    localparam logic [2:0] DST_TN   = 3'd5;
    localparam logic [2:0] DST_YP   = 3'd6;
    localparam logic [2:0] DST_UOUT = 3'd7;

    typedef struct packed {
        logic [1:0] op;
        logic [4:0] src_a;
        logic [4:0] src_b;
        logic [2:0] dst;
    } uop_t;

    localparam int STEP_W = 6;
    localparam logic [STEP_W-1:0] LAST_STEP = 6'd35;

    // One micro-operation per step; the order is the evaluation order of the
    // control law, so every saturation happens at the same point.
    function automatic uop_t uop_at(logic [STEP_W-1:0] step);
        uop_t u;
        unique case (step)
            // Remove the previous P contribution with the current gains.
            6'd0:  u = '{OP_MUL, SRC_B,    SRC_SL,   DST_T1};
            6'd1:  u = '{OP_SUB, SRC_T1,   SRC_ML,   DST_T1};
            6'd2:  u = '{OP_MUL, SRC_KP,   SRC_T1,   DST_T1};
            6'd3:  u = '{OP_SUB, SRC_ACC,  SRC_T1,   DST_ACC};
            // Remove the previous D contribution.
            6'd4:  u = '{OP_MUL, SRC_C,    SRC_SL,   DST_T1};
            6'd5:  u = '{OP_SUB, SRC_T1,   SRC_ML,   DST_EDM1};
            6'd6:  u = '{OP_MUL, SRC_C,    SRC_SO,   DST_T1};
            6'd7:  u = '{OP_SUB, SRC_T1,   SRC_MO,   DST_T1};
            6'd8:  u = '{OP_SUB, SRC_EDM1, SRC_T1,   DST_T1};
            6'd9:  u = '{OP_MUL, SRC_CD2,  SRC_T1,   DST_T1};
            6'd10: u = '{OP_MUL, SRC_CD1,  SRC_DB,   DST_T2};
            6'd11: u = '{OP_ADD, SRC_T2,   SRC_T1,   DST_T1};
            6'd12: u = '{OP_SUB, SRC_ACC,  SRC_T1,   DST_ACC};
            // Trapezoidal integration of the tracked error.
            6'd13: u = '{OP_SUB, SRC_W,    SRC_Y,    DST_T1};
            6'd14: u = '{OP_SUB, SRC_T1,   SRC_TN,   DST_T1};
            6'd15: u = '{OP_SUB, SRC_SL,   SRC_ML,   DST_T2};
            6'd16: u = '{OP_SUB, SRC_T2,   SRC_TB,   DST_T2};
            6'd17: u = '{OP_ADD, SRC_T1,   SRC_T2,   DST_T1};
            6'd18: u = '{OP_MUL, SRC_KI,   SRC_T1,   DST_T1};
            6'd19: u = '{OP_ADD, SRC_ACC,  SRC_T1,   DST_ACC};
            // Filtered derivative.
            6'd20: u = '{OP_MUL, SRC_C,    SRC_W,    DST_T1};
            6'd21: u = '{OP_SUB, SRC_T1,   SRC_Y,    DST_T1};
            6'd22: u = '{OP_SUB, SRC_T1,   SRC_EDM1, DST_T1};
            6'd23: u = '{OP_MUL, SRC_CD2,  SRC_T1,   DST_T1};
            6'd24: u = '{OP_MUL, SRC_CD1,  SRC_DN,   DST_T2};
            6'd25: u = '{OP_ADD, SRC_T2,   SRC_T1,   DST_DN};
            // Proportional term.
            6'd26: u = '{OP_MUL, SRC_B,    SRC_W,    DST_T1};
            6'd27: u = '{OP_SUB, SRC_T1,   SRC_Y,    DST_T1};
            6'd28: u = '{OP_MUL, SRC_KP,   SRC_T1,   DST_YP};
            // Sum, clamp and tracking feedback.
            6'd29: u = '{OP_ADD, SRC_YP,   SRC_ACC,  DST_T1};
            6'd30: u = '{OP_ADD, SRC_T1,   SRC_DN,   DST_T1};
            6'd31: u = '{OP_CLAMP, SRC_T1, SRC_T1,   DST_UOUT};
            6'd32: u = '{OP_SUB, SRC_T1,   SRC_UOUT, DST_T2};
            6'd33: u = '{OP_MUL, SRC_T2,   SRC_TG,   DST_TN};
            // Fold this tick's P and D parts into the integrator.
            6'd34: u = '{OP_ADD, SRC_YP,   SRC_DN,   DST_T1};
            6'd35: u = '{OP_ADD, SRC_ACC,  SRC_T1,   DST_ACC};
            default: u = '{OP_ADD, SRC_T1, SRC_T1,   DST_T1};
        endcase
        return u;
    endfunction

    // Saturating add or subtract.
    function automatic data_t sat_addsub(data_t a, data_t b, logic do_sub);
        logic signed [DATA_W:0] s;
        data_t r;
        if (do_sub) begin
            s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        end else begin
            s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        end
        if (s[DATA_W] != s[DATA_W-1]) begin
            r = s[DATA_W] ? DATA_MIN : DATA_MAX;
        end else begin
            r = s[DATA_W-1:0];
        end
        return r;
    endfunction

    // Exact product, shifted right with floor rounding, then saturated.
    function automatic data_t sat_mul(data_t a, data_t b);
        logic signed [PROD_W-1:0] prod;
        logic signed [PROD_W-1:0] q;
        logic [PROD_W-DATA_W:0]   q_top;
        data_t r;
        prod  = PROD_W'(a) * PROD_W'(b);
        q     = prod >>> FRAC_BITS;
        q_top = q[PROD_W-1:DATA_W-1];
        if ((&q_top) || !(|q_top)) begin
            r = q[DATA_W-1:0];
        end else begin
            r = q[PROD_W-1] ? DATA_MIN : DATA_MAX;
        end
        return r;
    endfunction

endpackage

[design/two_dof_pid_bumpless.sv]
// ============================================================================
// two_dof_pid_bumpless: two-degree-of-freedom PID controller
// Setpoint-weighted P and D terms, trapezoidal integrator, filtered
// derivative, back-calculation anti-windup and bumpless gain changes.
// ============================================================================

// Each word on the input channel carries one measurement and one setpoint and
// produces exactly one word on the result channel: the drive value, clamped to
// plus or minus out_limit, and a flag that is set when the clamp was active.
// All values are signed Q16.16 and every intermediate result saturates to 32
// bits. The arithmetic runs on one shared unit (a 32 by 32 multiplier with
// floor rounding and saturation, a saturating adder and the clamp) that a
// step counter walks through 36 micro-operations. A word therefore occupies
// the block from its acceptance through all 36 steps of the shared unit, and no
// new word is taken before it is through. s_ready is high only while no word
// is in work. The result sits in an output register; the next word is
// accepted as soon as the previous one finishes, whether or not its result has
// been taken, and only the last step waits when the output register is still
// full. Configuration registers are written through cfg_wr_en, cfg_addr and
// cfg_wr_data and should be changed only while the block is idle; the
// integrator subtracts the previous tick's P and D parts using the new gains,
// so a gain change does not bump the output.
module two_dof_pid_bumpless
    import tdpid_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [DATA_W-1:0]    cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_word_t             s_payload,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_word_t            m_payload
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    // Configuration registers.
    data_t              kp_reg, b_reg, c_reg, ki_reg, cd1_reg, cd2_reg, tg_reg;
    logic [LIMIT_W-1:0] limit_reg;

    // Controller state kept between words.
    data_t acc_reg, dn_reg, db_reg, tn_reg, tb_reg;
    data_t sl_reg, so_reg, ml_reg, mo_reg;

    // Working registers of the current word.
    data_t w_reg, y_reg, t1_reg, t2_reg, edm1_reg, yp_reg, uout_reg;
    logic  clamp_flag_reg;

    logic              state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              m_valid_reg, m_valid_next;
    out_word_t         m_payload_reg, m_payload_next;

    data_t acc_next, dn_next, db_next, tn_next, tb_next;
    data_t sl_next, so_next, ml_next, mo_next;
    data_t w_next, y_next, t1_next, t2_next, edm1_next, yp_next, uout_next;
    logic  clamp_flag_next;

    uop_t  uop;
    data_t opnd_a, opnd_b, alu_result;
    data_t lim_pos, lim_neg;
    logic  over_hi, under_lo;
    logic  out_free, step_go, in_accept;

    assign s_ready   = (state_reg == ST_IDLE);
    assign in_accept = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // The last step also loads the output register, so it waits for room there.
    assign out_free = !m_valid_reg || m_ready;
    assign step_go  = (state_reg == ST_RUN) && ((step_reg != LAST_STEP) || out_free);

    assign uop = uop_at(step_reg);

    // Operand selection for the shared unit.
    function automatic data_t pick(logic [4:0] sel, data_t kp, data_t b, data_t c,
                                   data_t ki, data_t cd1, data_t cd2, data_t tg,
                                   data_t acc, data_t dn, data_t db, data_t tn,
                                   data_t tb, data_t sl, data_t so, data_t ml,
                                   data_t mo, data_t w, data_t y, data_t t1,
                                   data_t t2, data_t edm1, data_t yp, data_t uout);
        data_t r;
        unique case (sel)
            SRC_KP:   r = kp;
            SRC_B:    r = b;
            SRC_C:    r = c;
            SRC_KI:   r = ki;
            SRC_CD1:  r = cd1;
            SRC_CD2:  r = cd2;
            SRC_TG:   r = tg;
            SRC_ACC:  r = acc;
            SRC_DN:   r = dn;
            SRC_DB:   r = db;
            SRC_TN:   r = tn;
            SRC_TB:   r = tb;
            SRC_SL:   r = sl;
            SRC_SO:   r = so;
            SRC_ML:   r = ml;
            SRC_MO:   r = mo;
            SRC_W:    r = w;
            SRC_Y:    r = y;
            SRC_T1:   r = t1;
            SRC_T2:   r = t2;
            SRC_EDM1: r = edm1;
            SRC_YP:   r = yp;
            SRC_UOUT: r = uout;
            default:  r = t1;
        endcase
        return r;
    endfunction

    always_comb begin
        opnd_a = pick(uop.src_a, kp_reg, b_reg, c_reg, ki_reg, cd1_reg, cd2_reg, tg_reg,
                      acc_reg, dn_reg, db_reg, tn_reg, tb_reg, sl_reg, so_reg, ml_reg,
                      mo_reg, w_reg, y_reg, t1_reg, t2_reg, edm1_reg, yp_reg, uout_reg);
        opnd_b = pick(uop.src_b, kp_reg, b_reg, c_reg, ki_reg, cd1_reg, cd2_reg, tg_reg,
                      acc_reg, dn_reg, db_reg, tn_reg, tb_reg, sl_reg, so_reg, ml_reg,
                      mo_reg, w_reg, y_reg, t1_reg, t2_reg, edm1_reg, yp_reg, uout_reg);
    end

    // The clamp limit is a positive 31-bit magnitude, so its negation fits.
    assign lim_pos  = data_t'({1'b0, limit_reg});
    assign lim_neg  = -lim_pos;
    assign over_hi  = (opnd_a > lim_pos);
    assign under_lo = (opnd_a < lim_neg);

    // Shared arithmetic unit.
    always_comb begin
        unique case (uop.op)
            OP_MUL:   alu_result = sat_mul(opnd_a, opnd_b);
            OP_ADD:   alu_result = sat_addsub(opnd_a, opnd_b, 1'b0);
            OP_SUB:   alu_result = sat_addsub(opnd_a, opnd_b, 1'b1);
            OP_CLAMP: begin
                priority if (over_hi) begin
                    alu_result = lim_pos;
                end else if (under_lo) begin
                    alu_result = lim_neg;
                end else begin
                    alu_result = opnd_a;
                end
            end
            default:  alu_result = opnd_a;
        endcase
    end

    // Sequencer and result write-back.
    always_comb begin
        state_next      = state_reg;
        step_next       = step_reg;
        m_valid_next    = m_valid_reg;
        m_payload_next  = m_payload_reg;
        acc_next        = acc_reg;
        dn_next         = dn_reg;
        db_next         = db_reg;
        tn_next         = tn_reg;
        tb_next         = tb_reg;
        sl_next         = sl_reg;
        so_next         = so_reg;
        ml_next         = ml_reg;
        mo_next         = mo_reg;
        w_next          = w_reg;
        y_next          = y_reg;
        t1_next         = t1_reg;
        t2_next         = t2_reg;
        edm1_next       = edm1_reg;
        yp_next         = yp_reg;
        uout_next       = uout_reg;
        clamp_flag_next = clamp_flag_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (in_accept) begin
            w_next     = s_payload.setpoint;
            y_next     = s_payload.measured;
            state_next = ST_RUN;
            step_next  = '0;
        end

        if (step_go) begin
            unique case (uop.dst)
                DST_T1:   t1_next   = alu_result;
                DST_T2:   t2_next   = alu_result;
                DST_EDM1: edm1_next = alu_result;
                DST_ACC:  acc_next  = alu_result;
                DST_DN: begin
                    db_next = dn_reg;
                    dn_next = alu_result;
                end
                DST_TN: begin
                    tb_next = tn_reg;
                    tn_next = alu_result;
                end
                DST_YP:   yp_next   = alu_result;
                DST_UOUT: begin
                    uout_next       = alu_result;
                    clamp_flag_next = over_hi || under_lo;
                end
                default:  t1_next   = alu_result;
            endcase

            if (step_reg == LAST_STEP) begin
                // The word is done: shift the history and publish the result.
                so_next                = sl_reg;
                mo_next                = ml_reg;
                sl_next                = w_reg;
                ml_next                = y_reg;
                m_valid_next           = 1'b1;
                m_payload_next.drive   = uout_reg;
                m_payload_next.clamped = clamp_flag_reg;
                state_next             = ST_IDLE;
            end else begin
                step_next = step_reg + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
            acc_reg     <= '0;
            dn_reg      <= '0;
            db_reg      <= '0;
            tn_reg      <= '0;
            tb_reg      <= '0;
            sl_reg      <= '0;
            so_reg      <= '0;
            ml_reg      <= '0;
            mo_reg      <= '0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
            acc_reg     <= acc_next;
            dn_reg      <= dn_next;
            db_reg      <= db_next;
            tn_reg      <= tn_next;
            tb_reg      <= tb_next;
            sl_reg      <= sl_next;
            so_reg      <= so_next;
            ml_reg      <= ml_next;
            mo_reg      <= mo_next;
        end
        m_payload_reg  <= m_payload_next;
        w_reg          <= w_next;
        y_reg          <= y_next;
        t1_reg         <= t1_next;
        t2_reg         <= t2_next;
        edm1_reg       <= edm1_next;
        yp_reg         <= yp_next;
        uout_reg       <= uout_next;
        clamp_flag_reg <= clamp_flag_next;
    end

    // Configuration registers; a write takes effect at once.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg    <= '0;
            b_reg     <= DATA_ONE;
            c_reg     <= DATA_ONE;
            ki_reg    <= '0;
            cd1_reg   <= '0;
            cd2_reg   <= '0;
            limit_reg <= LIMIT_W'(DATA_ONE);
            tg_reg    <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_PROP_GAIN:    kp_reg    <= cfg_wr_data;
                REG_WEIGHT_PROP:  b_reg     <= cfg_wr_data;
                REG_WEIGHT_DERIV: c_reg     <= cfg_wr_data;
                REG_INTEG_COEF:   ki_reg    <= cfg_wr_data;
                REG_DERIV_POLE:   cd1_reg   <= cfg_wr_data;
                REG_DERIV_COEF:   cd2_reg   <= cfg_wr_data;
                REG_OUT_LIMIT:    limit_reg <= cfg_wr_data[LIMIT_W-1:0];
                REG_TRACK_GAIN:   tg_reg    <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // A new result appears only right after the last step of the sequence.
    a_result_after_last_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_RUN && step_reg == LAST_STEP))
        else $error("result word appeared outside the last step");

    // An accepted word always starts the sequence from its first step.
    a_accept_starts_sequence: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_RUN && step_reg == '0))
        else $error("accepted word did not start the sequence");

    // A clamped result sits exactly on one of the two limits.
    a_clamped_on_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.clamped) |->
            (m_payload.drive == lim_pos || m_payload.drive == lim_neg))
        else $error("clamped result is not on the limit");

    // The step counter never runs past the end of the microcode.
    a_step_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (step_reg <= LAST_STEP))
        else $error("step counter ran past the last step");

endmodule

[tb/two_dof_pid_bumpless_tb.sv]
`timescale 1ns / 100ps
// ============================================================================
// two_dof_pid_bumpless_tb: self-checking bench for the 2-DOF PID controller
// Drives measurement and setpoint words through the valid/ready input channel,
// predicts every drive word with a cycle-free fixed-point model of the control
// law and checks each result word against it, under random idling on both
// channels and a sequence of register settings that includes the extremes.
// ============================================================================
module two_dof_pid_bumpless_tb;
    import tdpid_pkg::*;

    localparam int     CLK_HALF     = 6;
    localparam int     CYCLE_LIMIT  = 1_000_000;
    localparam int     SWEEP_PHASES = 12;
    localparam int     PHASE_WORDS  = 125;
    localparam int     DRAIN_CYCLES = 40;
    localparam int     Q            = 65536;
    localparam longint Q_MAX        = (64'sd1 <<< (DATA_W - 1)) - 1;
    localparam longint Q_MIN        = -Q_MAX - 1;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [DATA_W-1:0]    cfg_wr_data;
    logic                 s_valid;
    logic                 s_ready;
    in_word_t             s_payload;
    logic                 m_valid;
    logic                 m_ready;
    out_word_t            m_payload;

    two_dof_pid_bumpless dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_payload   (s_payload),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_payload   (m_payload)
    );

    // Shadow copy of the configuration registers, starting from their reset values.
    longint kp    = 0;
    longint b_w   = longint'(DATA_ONE);
    longint c_w   = longint'(DATA_ONE);
    longint ki    = 0;
    longint cd1   = 0;
    longint cd2   = 0;
    longint u_lim = longint'(DATA_ONE);
    longint tg    = 0;

    // Shadow copy of the controller state, all cleared by reset.
    longint integ   = 0;
    longint d_now   = 0;
    longint d_prev  = 0;
    longint t_now   = 0;
    longint t_prev  = 0;
    longint w_last  = 0;
    longint w_older = 0;
    longint y_last  = 0;
    longint y_older = 0;

    // Drive words predicted for accepted input words, oldest first.
    out_word_t   predicted_drive_q[$];
    int          error_count = 0;
    int unsigned cycle_count = 0;
    // When set, neither channel inserts idle cycles.
    bit          steady_flow = 1'b0;

    // ------------------------------------------------------------------------
    // Fixed-point arithmetic of the control law. Every value is carried in a
    // 64-bit integer and saturated back to the 32-bit range after each step.
    // ------------------------------------------------------------------------
    function automatic longint clip(longint v);
        if (v > Q_MAX) return Q_MAX;
        if (v < Q_MIN) return Q_MIN;
        return v;
    endfunction

    function automatic longint q_add(longint a, longint b);
        return clip(a + b);
    endfunction

    function automatic longint q_sub(longint a, longint b);
        return clip(a - b);
    endfunction

    // The exact product of two 32-bit values fits in the 64-bit integer, and the
    // arithmetic shift rounds toward minus infinity.
    function automatic longint q_mul(longint a, longint b);
        longint p;
        p = (a * b) >>> FRAC_BITS;
        return clip(p);
    endfunction

    // One controller tick: updates the shadow state and returns the drive word
    // the block must produce for this measurement and setpoint.
    function automatic out_word_t step_controller(data_t meas, data_t sp);
        longint    y;
        longint    w;
        longint    edm1;
        longint    edm2;
        longint    e;
        longint    ekm1;
        longint    ep;
        longint    ed;
        longint    yp;
        longint    u_raw;
        longint    u_out;
        out_word_t r;
        y = longint'($signed(meas));
        w = longint'($signed(sp));

        // Take the previous tick's P and D parts back out with today's gains,
        // which is what keeps a gain change free of a step in the output.
        integ = q_sub(integ, q_mul(kp, q_sub(q_mul(b_w, w_last), y_last)));
        edm1  = q_sub(q_mul(c_w, w_last), y_last);
        edm2  = q_sub(q_mul(c_w, w_older), y_older);
        integ = q_sub(integ, q_add(q_mul(cd1, d_prev), q_mul(cd2, q_sub(edm1, edm2))));

        // Trapezoidal integration of the error, corrected by the tracking term.
        e     = q_sub(q_sub(w, y), t_now);
        ekm1  = q_sub(q_sub(w_last, y_last), t_prev);
        ep    = q_sub(q_mul(b_w, w), y);
        ed    = q_sub(q_mul(c_w, w), y);
        integ = q_add(integ, q_mul(ki, q_add(e, ekm1)));

        d_prev = d_now;
        d_now  = q_add(q_mul(cd1, d_now), q_mul(cd2, q_sub(ed, edm1)));
        yp     = q_mul(kp, ep);

        u_raw = q_add(q_add(yp, integ), d_now);
        u_out = u_raw;
        if (u_raw > u_lim) begin
            u_out = u_lim;
        end else if (u_raw < -u_lim) begin
            u_out = -u_lim;
        end

        // Back-calculation: the clamped excess, scaled by the tracking gain,
        // enters the next tick's error.
        t_prev = t_now;
        t_now  = q_mul(q_sub(u_raw, u_out), tg);

        w_older = w_last;
        y_older = y_last;
        w_last  = w;
        y_last  = y;

        integ = q_add(integ, q_add(yp, d_now));

        r.drive   = data_t'(u_out);
        r.clamped = (u_out != u_raw);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Random values.
    // ------------------------------------------------------------------------

    // Idle length for either channel: mostly none or a few cycles, now and
    // then a long pause.
    function automatic int pick_gap();
        int r;
        if (steady_flow) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // A Q16.16 value: usually within plus or minus 4.0, sometimes one of the
    // corner values, sometimes any 32-bit pattern.
    function automatic data_t pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return data_t'($urandom);
        if (r == 1) begin
            case ($urandom_range(0, 5))
                0:       return DATA_MAX;
                1:       return DATA_MIN;
                2:       return data_t'(0);
                3:       return data_t'(-1);
                4:       return DATA_ONE;
                default: return -DATA_ONE;
            endcase
        end
        return data_t'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
    endfunction

    // ------------------------------------------------------------------------
    // Clock, receiver idling, result checking and the run limit.
    // ------------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #(CLK_HALF) aclk = ~aclk;
    end

    // The result side drops m_ready for random stretches. The level is set at
    // the falling edge, so it is stable when the block samples it.
    initial begin : result_backpressure
        int stall;
        stall   = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall > 0) begin
                m_ready = 1'b0;
                stall   = stall - 1;
            end else begin
                m_ready = 1'b1;
                if ($urandom_range(0, 4) == 0) stall = pick_gap();
            end
        end
    end

    // Each result word accepted at a rising edge is compared with the oldest
    // prediction. Values read here are the ones from before the edge.
    always @(posedge aclk) begin : check_results
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (predicted_drive_q.size() == 0) begin
                $display("%0t: result word with no prediction pending: drive %h clamped %b",
                         $time, m_payload.drive, m_payload.clamped);
                error_count = error_count + 1;
            end else begin
                want = predicted_drive_q.pop_front();
                if (m_payload.drive !== want.drive) begin
                    $display("%0t: drive mismatch: expected %h actual %h",
                             $time, want.drive, m_payload.drive);
                    error_count = error_count + 1;
                end
                if (m_payload.clamped !== want.clamped) begin
                    $display("%0t: clamped mismatch: expected %b actual %b",
                             $time, want.clamped, m_payload.clamped);
                    error_count = error_count + 1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Shared stimulus tasks. All of them start and end at a falling edge.
    // ------------------------------------------------------------------------

    // Offers one word, holds it until the block takes it, and records the
    // prediction at the accepting edge. s_valid drops at the falling edge
    // after acceptance, so a stale payload is never offered again.
    task automatic send_sample(data_t meas, data_t sp);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_payload.measured = meas;
        s_payload.setpoint = sp;
        s_valid            = 1'b1;
        do @(posedge aclk); while (!s_ready);
        predicted_drive_q.push_back(step_controller(meas, sp));
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    // Stops offering words and waits until every predicted word has been
    // taken; the block is idle from then on, the short pause is margin.
    task automatic wait_idle();
        s_valid = 1'b0;
        while (predicted_drive_q.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
        cfg_wr_en   = 1'b1;
        cfg_addr    = idx;
        cfg_wr_data = value;
        case (idx)
            REG_PROP_GAIN:    kp  = longint'($signed(value));
            REG_WEIGHT_PROP:  b_w = longint'($signed(value));
            REG_WEIGHT_DERIV: c_w = longint'($signed(value));
            REG_INTEG_COEF:   ki  = longint'($signed(value));
            REG_DERIV_POLE:   cd1 = longint'($signed(value));
            REG_DERIV_COEF:   cd2 = longint'($signed(value));
            // Only the low 31 bits of the limit are kept; bit 31 is dropped.
            REG_OUT_LIMIT:    u_lim = longint'({1'b0, value[LIMIT_W-1:0]});
            REG_TRACK_GAIN:   tg  = longint'($signed(value));
            default:          ;
        endcase
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // Writes the whole register set once the block has gone idle.
    task automatic load_gains(logic [DATA_W-1:0] p, logic [DATA_W-1:0] bw,
                              logic [DATA_W-1:0] cw, logic [DATA_W-1:0] ic,
                              logic [DATA_W-1:0] pole, logic [DATA_W-1:0] dc,
                              logic [DATA_W-1:0] lim, logic [DATA_W-1:0] trk);
        wait_idle();
        write_reg(REG_PROP_GAIN, p);
        write_reg(REG_WEIGHT_PROP, bw);
        write_reg(REG_WEIGHT_DERIV, cw);
        write_reg(REG_INTEG_COEF, ic);
        write_reg(REG_DERIV_POLE, pole);
        write_reg(REG_DERIV_COEF, dc);
        write_reg(REG_OUT_LIMIT, lim);
        write_reg(REG_TRACK_GAIN, trk);
    endtask

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Registers still at their reset values: no gain at all, so the drive
    // must stay at zero even for the widest inputs.
    task automatic test_reset_defaults();
        send_sample(data_t'(0), data_t'(0));
        send_sample(DATA_MAX, DATA_MIN);
        send_sample(DATA_MIN, DATA_MAX);
    endtask

    // Pure P control with a setpoint weight of one half.
    task automatic test_proportional();
        load_gains(2 * Q, Q / 2, Q, 0, 0, 0, 16 * Q, 0);
        send_sample(data_t'(Q), data_t'(2 * Q));
        send_sample(data_t'(-Q), data_t'(3 * Q));
        send_sample(data_t'(0), data_t'(-Q));
    endtask

    // The integrator ramps on a constant error, then the error is brought to zero.
    task automatic test_integrator();
        load_gains(0, Q, Q, Q / 4, 0, 0, 32 * Q, 0);
        repeat (3) send_sample(data_t'(0), data_t'(Q));
        send_sample(data_t'(Q), data_t'(Q));
    endtask

    // Filtered derivative with a setpoint weight below one.
    task automatic test_derivative();
        load_gains(0, Q, 3 * Q / 4, 0, Q / 2, Q, 32 * Q, 0);
        send_sample(data_t'(0), data_t'(Q));
        send_sample(data_t'(Q / 2), data_t'(Q));
        send_sample(data_t'(Q), data_t'(Q));
        send_sample(data_t'(Q), data_t'(-Q));
    endtask

    // Every coefficient at a corner, so products and sums saturate. The
    // limit is written with bit 31 set, which must be ignored.
    task automatic test_overflow();
        load_gains(DATA_MAX, DATA_MIN, DATA_MAX, DATA_MAX, DATA_MIN, DATA_MAX,
                   32'hFFFF_FFFF, DATA_MAX);
        send_sample(DATA_MIN, DATA_MAX);
        send_sample(DATA_MAX, DATA_MIN);
        send_sample(data_t'(-1), data_t'(0));
    endtask

    // A large step drives the output into the clamp, and the tracking gain
    // bleeds the excess out of the integrator. A zero limit clamps everything.
    task automatic test_anti_windup();
        load_gains(Q, Q, Q, Q, 0, 0, Q, Q / 2);
        repeat (3) send_sample(data_t'(0), data_t'(4 * Q));
        send_sample(data_t'(0), data_t'(0));
        load_gains(Q, Q, Q, Q, 0, 0, 0, Q / 2);
        send_sample(data_t'(Q), data_t'(-Q));
    endtask

    // Raising Kp between ticks must not make the output jump.
    task automatic test_bumpless_gain_change();
        load_gains(Q, Q, Q, Q / 16, 0, 0, 8 * Q, 0);
        repeat (2) send_sample(data_t'(0), data_t'(Q));
        load_gains(3 * Q, Q, Q, Q / 16, 0, 0, 8 * Q, 0);
        repeat (2) send_sample(data_t'(0), data_t'(Q));
    endtask

    // Random register sets, one per phase. Most words follow a plausible loop:
    // a setpoint that holds and steps now and then, and a measurement that
    // drifts in small increments. The rest are arbitrary words. The first two
    // phases use all-maximum and all-minimum settings, and every fourth phase
    // runs with no idling on either side.
    task automatic test_random_sweep();
        data_t sp;
        data_t meas;
        int    delta;
        for (int ph = 0; ph < SWEEP_PHASES; ph++) begin
            case (ph)
                0: load_gains(DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX,
                              32'h7FFF_FFFF, DATA_MAX);
                1: load_gains(DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN,
                              0, DATA_MIN);
                default: load_gains(pick_value(), pick_value(), pick_value(), pick_value(),
                                    pick_value(), pick_value(),
                                    ($urandom_range(0, 3) == 0) ? $urandom
                                                                : $urandom_range(0, 8 * Q),
                                    ($urandom_range(0, 2) == 0) ? 0 : pick_value());
            endcase
            steady_flow = (ph % 4 == 3);
            sp   = pick_value();
            meas = pick_value();
            for (int i = 0; i < PHASE_WORDS; i++) begin
                if ($urandom_range(0, 99) < 85) begin
                    if ($urandom_range(0, 19) == 0) sp = pick_value();
                    delta = int'($urandom_range(0, 8192)) - 4096;
                    meas  = data_t'(clip(longint'(meas) + delta));
                    send_sample(meas, sp);
                end else begin
                    send_sample(pick_value(), pick_value());
                end
            end
        end
        steady_flow = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_addr    = '0;
        cfg_wr_data = '0;
        s_valid     = 1'b0;
        s_payload   = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_reset_defaults();
        test_proportional();
        test_integrator();
        test_derivative();
        test_overflow();
        test_anti_windup();
        test_bumpless_gain_change();
        test_random_sweep();

        // All words are in; wait for the last results, then a short margin in
        // which any stray result word would still be caught.
        s_valid = 1'b0;
        while (predicted_drive_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0 && predicted_drive_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
